>>> rtl/tlm_shunt_node_scatter_assert.svh
// Assertion macros shared by the RTL of the shunt node scatter block.
// Expects clk and rst in the scope where a macro is used.
`ifndef TLM_SHUNT_NODE_SCATTER_ASSERT_SVH
`define TLM_SHUNT_NODE_SCATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TSNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tsns assertion failed");
`define TSNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsns assertion failed");
`else
`define TSNS_ASSERT(lbl, prop)
`define TSNS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> rtl/tsns_pkg.sv
// Types, register codes and fixed-point helpers for the shunt node scatter.
// No dependencies.
package tsns_pkg;

  localparam int LINK_PORTS = 4;
  localparam int WIDE_W     = 56;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] incident_0;
    logic signed [31:0] incident_1;
    logic signed [31:0] incident_2;
    logic signed [31:0] incident_3;
    logic signed [31:0] incident_stub;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] reflected_0;
    logic signed [31:0] reflected_1;
    logic signed [31:0] reflected_2;
    logic signed [31:0] reflected_3;
    logic signed [31:0] reflected_stub;
    logic signed [31:0] node_voltage;
  } out_item_t;

  localparam logic [7:0] REG_MODE       = 8'd0;
  localparam logic [7:0] REG_LINK_GAIN  = 8'd1;
  localparam logic [7:0] REG_STUB_GAIN  = 8'd2;
  localparam logic [7:0] REG_PML_NORM   = 8'd3;
  localparam logic [7:0] REG_SIGMA_X_DT = 8'd4;
  localparam logic [7:0] REG_SIGMA_Y_DT = 8'd5;
  localparam logic [7:0] REG_DECAY_X    = 8'd6;
  localparam logic [7:0] REG_DECAY_Y    = 8'd7;

  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_DIEL = 2'd1;
  localparam logic [1:0] MODE_PML  = 2'd2;

  localparam logic [31:0] Q30_HALF = 32'h2000_0000;
  localparam wide_t OPND_LIM = wide_t'(64'sh7FFF_FFFF_FFFF);

  function automatic logic signed [31:0] sat32(input wide_t x);
    if (x > wide_t'(64'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -wide_t'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

>>> rtl/tlm_shunt_node_scatter.sv
// 2D TLM shunt node scatter (free-space, dielectric, PML free-space).
// Uses tsns_pkg and the assertion macros in tlm_shunt_node_scatter_assert.svh.
//
// Usage: one input beat (four link incident voltages and the stub incident
// voltage, Q16.16) gives one output beat (five reflected voltages and the node
// voltage). Both channels are valid/ready. Registers are written through the
// cfg channel (index, data), which is always ready; the user must write them
// only while the block is idle, which the block itself does not enforce.
// All products run through one shared Q2.30 multiplier; each product steps
// through operand select, low partial product, high partial product, and
// round and write back, then a finish step forms the outputs. Products per
// item: dielectric 2, free-space 5, PML 12. One item is worked at a time: a
// new input beat is taken only after the last item leaves the finish state.
// in_ready stays high while an earlier result waits in the output register;
// if the receiver stalls, the finished item holds in the finish state until
// the output register frees up.
// Reset (rst, synchronous) loads the register defaults and clears the PML
// history and all handshake state.
`include "tlm_shunt_node_scatter_assert.svh"

module tlm_shunt_node_scatter
  import tsns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_OPND, S_LO, S_HI, S_WB, S_FIN
  } state_t;

  state_t state;

  // configuration
  logic [1:0]  mode;
  logic [31:0] link_gain, stub_gain, pml_norm, sigma_x_dt, sigma_y_dt;
  logic [30:0] decay_x, decay_y;

  // PML history
  logic signed [31:0] prev_incident [LINK_PORTS];
  logic signed [31:0] prev_port_current [LINK_PORTS];
  logic signed [31:0] prev_total_voltage;
  logic signed [31:0] prev_total_current;

  // item working set
  logic signed [31:0] vi [LINK_PORTS];
  logic signed [31:0] vstub;
  logic signed [33:0] sum;
  wide_t              isum;
  wide_t              prod [12];
  logic [3:0]         op;
  logic [3:0]         last_op;

  // shared multiplier
  wide_t       x_reg;
  logic [31:0] g_reg;
  logic [79:0] acc;
  logic        neg;

  wide_t       opnd;
  logic [31:0] gain;
  wide_t       x_clamp;
  logic [46:0] mag;
  logic [49:0] rnd;
  wide_t       r_s;
  wide_t       wb_val;
  logic [1:0]  k_op;
  logic [1:0]  k_m1;
  logic        is_pml, is_diel;
  logic        fin_go;

  assign is_pml  = (mode == MODE_PML);
  assign is_diel = (mode == MODE_DIEL);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign k_op = op[1:0];
  assign k_m1 = 2'(op - 4'd1);
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    if (is_pml) begin
      last_op = 4'd11;
    end else if (is_diel) begin
      last_op = 4'd1;
    end else begin
      last_op = 4'd4;
    end
  end

  // operand and gain for the current product
  always_comb begin
    opnd = '0;
    gain = '0;
    if (is_pml) begin
      if (op < 4'd4) begin
        opnd = wide_t'(vi[k_op]) + wide_t'(prev_incident[k_op]);
        gain = k_op[0] ? sigma_y_dt : sigma_x_dt;
      end else if (op == 4'd4) begin
        opnd = wide_t'(sum) <<< 1;
        gain = pml_norm;
      end else if (op == 4'd5) begin
        opnd = wide_t'(prev_total_voltage);
        gain = sigma_x_dt;
      end else if (op == 4'd6) begin
        opnd = wide_t'(prev_total_voltage);
        gain = sigma_y_dt;
      end else if (op == 4'd7) begin
        opnd = isum - wide_t'(prev_total_current)
             + (wide_t'(prev_total_voltage) <<< 2) - prod[5] - prod[6];
        gain = pml_norm;
      end else begin
        opnd = prod[4] - wide_t'(vi[k_op]) + prod[7];
        gain = k_op[0] ? {1'b0, decay_x} : {1'b0, decay_y};
      end
    end else if (is_diel) begin
      opnd = (op == 4'd0) ? wide_t'(sum) : wide_t'(vstub);
      gain = (op == 4'd0) ? link_gain : stub_gain;
    end else begin
      opnd = (op == 4'd0) ? wide_t'(sum)
                          : wide_t'(sum) - (wide_t'(vi[k_m1]) <<< 1);
      gain = Q30_HALF;
    end
  end

  // clamp and magnitude of the registered operand
  always_comb begin
    if (x_reg > OPND_LIM) begin
      x_clamp = OPND_LIM;
    end else if (x_reg < -OPND_LIM) begin
      x_clamp = -OPND_LIM;
    end else begin
      x_clamp = x_reg;
    end
    mag = x_clamp[WIDE_W-1] ? 47'(-x_clamp) : x_clamp[46:0];
  end

  // round to nearest, ties away from zero
  assign rnd = 50'((acc + 80'h2000_0000) >> 30);
  assign r_s = neg ? -wide_t'(rnd) : wide_t'(rnd);
  assign wb_val = (is_pml && op < 4'd4)
                ? r_s - (wide_t'(prev_incident[k_op]) <<< 1)
                  + wide_t'(prev_port_current[k_op])
                : r_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mode <= MODE_FREE;
      link_gain <= 32'd536870912;
      stub_gain <= '0;
      pml_norm <= 32'd268435456;
      sigma_x_dt <= '0;
      sigma_y_dt <= '0;
      decay_x <= 31'd1073741824;
      decay_y <= 31'd1073741824;
      for (int i = 0; i < LINK_PORTS; i++) begin
        prev_incident[i] <= '0;
        prev_port_current[i] <= '0;
      end
      prev_total_voltage <= '0;
      prev_total_current <= '0;
      op <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:       mode <= cfg_data[1:0];
          REG_LINK_GAIN:  link_gain <= cfg_data;
          REG_STUB_GAIN:  stub_gain <= cfg_data;
          REG_PML_NORM:   pml_norm <= cfg_data;
          REG_SIGMA_X_DT: sigma_x_dt <= cfg_data;
          REG_SIGMA_Y_DT: sigma_y_dt <= cfg_data;
          REG_DECAY_X:    decay_x <= cfg_data[30:0];
          REG_DECAY_Y:    decay_y <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vi[0] <= in_data.incident_0;
            vi[1] <= in_data.incident_1;
            vi[2] <= in_data.incident_2;
            vi[3] <= in_data.incident_3;
            vstub <= in_data.incident_stub;
            sum <= 34'(in_data.incident_0) + 34'(in_data.incident_1)
                 + 34'(in_data.incident_2) + 34'(in_data.incident_3);
            isum <= '0;
            op <= '0;
            state <= S_OPND;
          end
        end
        S_OPND: begin
          x_reg <= opnd;
          g_reg <= gain;
          state <= S_LO;
        end
        S_LO: begin
          neg <= x_clamp[WIDE_W-1];
          acc <= 80'(mag[23:0]) * 80'(g_reg);
          state <= S_HI;
        end
        S_HI: begin
          acc <= acc + ((80'(mag[46:24]) * 80'(g_reg)) << 24);
          state <= S_WB;
        end
        S_WB: begin
          prod[op] <= wb_val;
          if (is_pml && op < 4'd4) begin
            isum <= isum + wb_val;
          end
          if (op == last_op) begin
            state <= S_FIN;
          end else begin
            op <= op + 4'd1;
            state <= S_OPND;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
            if (is_pml) begin
              out_data.node_voltage <= sat32(prod[4] + prod[7]);
              out_data.reflected_0 <= sat32(prod[8]);
              out_data.reflected_1 <= sat32(prod[9]);
              out_data.reflected_2 <= sat32(prod[10]);
              out_data.reflected_3 <= sat32(prod[11]);
              out_data.reflected_stub <= '0;
              for (int i = 0; i < LINK_PORTS; i++) begin
                prev_port_current[i] <= sat32(prod[i] + (wide_t'(vi[i]) <<< 1));
                prev_incident[i] <= vi[i];
              end
              prev_total_current <= sat32(isum + (wide_t'(sum) <<< 1));
              prev_total_voltage <= sat32(prod[4] + prod[7]);
            end else if (is_diel) begin
              out_data.node_voltage <= sat32(prod[0] + prod[1]);
              out_data.reflected_0 <=
                sat32(wide_t'(sat32(prod[0] + prod[1])) - wide_t'(vi[0]));
              out_data.reflected_1 <=
                sat32(wide_t'(sat32(prod[0] + prod[1])) - wide_t'(vi[1]));
              out_data.reflected_2 <=
                sat32(wide_t'(sat32(prod[0] + prod[1])) - wide_t'(vi[2]));
              out_data.reflected_3 <=
                sat32(wide_t'(sat32(prod[0] + prod[1])) - wide_t'(vi[3]));
              out_data.reflected_stub <=
                sat32(wide_t'(sat32(prod[0] + prod[1])) - wide_t'(vstub));
            end else begin
              out_data.node_voltage <= sat32(prod[0]);
              out_data.reflected_0 <= sat32(prod[1]);
              out_data.reflected_1 <= sat32(prod[2]);
              out_data.reflected_2 <= sat32(prod[3]);
              out_data.reflected_3 <= sat32(prod[4]);
              out_data.reflected_stub <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TSNS_ASSERT_IMP(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TSNS_ASSERT(a_op_in_range, (state == S_IDLE) || (op <= last_op))
  `TSNS_ASSERT_IMP(a_fin_delivers, fin_go, out_valid && in_ready)
  `TSNS_ASSERT(a_stub_zero, !out_valid || is_diel || (out_data.reflected_stub == 32'sd0))

endmodule
